[design/rbs_pkg.sv]
`default_nettype none

package rbs_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned TagW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned Axes    = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [TagW-1:0]          tag_t;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_ORIGIN_Z      = 3'd2,
    CFG_RECIP_DIR_X   = 3'd3,
    CFG_RECIP_DIR_Y   = 3'd4,
    CFG_RECIP_DIR_Z   = 3'd5,
    CFG_INTERVAL_LOW  = 3'd6,
    CFG_INTERVAL_HIGH = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    tag_t   box_tag;
  } box_t;

  typedef struct packed {
    logic   is_hit;
    coord_t near_dist;
    coord_t far_dist;
    tag_t   tag_out;
  } result_t;

endpackage

`default_nettype wire

[design/rbs_slab_lane.sv]
`default_nettype none

// (bound - origin) * recip, floored by FRAC_BITS and saturated to 32 bits.
// Three register stages: difference, product, scaled distance.
module rbs_slab_lane
  import rbs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire coord_t bound_i,
  input  wire coord_t origin_i,
  input  wire coord_t recip_i,
  output coord_t      dist_o
);

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = DiffW + CoordW;

  localparam logic signed [ProdW-1:0] SatHi = ProdW'(CoordMax);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(CoordMin);

  logic signed [DiffW-1:0] diff_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ProdW-1:0] shift_d;
  coord_t                  dist_d, dist_q;

  // exact 33-bit difference
  always_ff @(posedge clk_i) begin
    diff_q <= {bound_i[CoordW-1], bound_i} - {origin_i[CoordW-1], origin_i};
  end

  assign prod_d = diff_q * recip_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // arithmetic shift rounds toward minus infinity
  assign shift_d = prod_q >>> FRAC_BITS;

  always_comb begin
    if (shift_d > SatHi) begin
      dist_d = CoordMax;
    end else if (shift_d < SatLo) begin
      dist_d = CoordMin;
    end else begin
      dist_d = shift_d[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

[design/ray_box_slab_test.sv]
// Ray versus axis-aligned box slab test.
// The ray (origin, reciprocal direction, accepted interval) is loaded through
// the register write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must do
// so only while no box is in flight, which the block does not enforce. Boxes
// enter on box_i; a transaction is taken at a rising edge with start_i high
// and busy_o low. busy_o is always low: a new box can enter in every cycle.
// Each box yields one result on res_o, marked by done_o for one cycle, once
// it has passed the stages below (throughput 1 box per cycle).
// Stages: bound minus origin, multiply by the reciprocal (six lanes side by
// side), floor and saturate, per-axis entry/exit ordering, interval narrowing.
// is_hit compares the registered far and near distances.
// The receiver cannot stall, so results are never held back.
// Reset clears the in-flight valid bits, dropping any boxes in flight, and
// restores the ray registers: origin 0, reciprocal 1.0, interval [0, max].
`default_nettype none

module ray_box_slab_test
  import rbs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire coord_t             cfg_data_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire box_t               box_i,
  output logic                    done_o,
  output result_t                 res_o
);

  localparam int unsigned Depth = 5;
  localparam int unsigned Lanes = 2 * Axes;
  localparam coord_t      RecipOne = CoordW'(1) << FRAC_BITS;

  coord_t origin_q [Axes];
  coord_t recip_q  [Axes];
  coord_t low_q, high_q;

  logic [Depth-1:0] vld_q;
  tag_t             tag_q [Depth];

  coord_t bound     [Lanes];
  coord_t lane_dist [Lanes];
  coord_t entry_d [Axes];
  coord_t exit_d  [Axes];
  coord_t entry_q [Axes];
  coord_t exit_q  [Axes];
  coord_t lo_a, lo_b, hi_a, hi_b;
  coord_t lo_d, hi_d, lo_q, hi_q;

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ray registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Axes; i++) begin
        origin_q[i] <= '0;
        recip_q[i]  <= RecipOne;
      end
      low_q  <= '0;
      high_q <= CoordMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:      origin_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:      origin_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:      origin_q[2] <= cfg_data_i;
        CFG_RECIP_DIR_X:   recip_q[0]  <= cfg_data_i;
        CFG_RECIP_DIR_Y:   recip_q[1]  <= cfg_data_i;
        CFG_RECIP_DIR_Z:   recip_q[2]  <= cfg_data_i;
        CFG_INTERVAL_LOW:  low_q       <= cfg_data_i;
        CFG_INTERVAL_HIGH: high_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= box_i.box_tag;
    for (int i = 1; i < Depth; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
  end

  // lanes 0..2 take the lower corner, 3..5 the upper corner
  assign bound[0] = box_i.box_min_x;
  assign bound[1] = box_i.box_min_y;
  assign bound[2] = box_i.box_min_z;
  assign bound[3] = box_i.box_max_x;
  assign bound[4] = box_i.box_max_y;
  assign bound[5] = box_i.box_max_z;

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    rbs_slab_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .bound_i (bound[l]),
      .origin_i(origin_q[l % Axes]),
      .recip_i (recip_q[l % Axes]),
      .dist_o  (lane_dist[l])
    );
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      if (lane_dist[a] < lane_dist[a+Axes]) begin
        entry_d[a] = lane_dist[a];
        exit_d[a]  = lane_dist[a+Axes];
      end else begin
        entry_d[a] = lane_dist[a+Axes];
        exit_d[a]  = lane_dist[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    exit_q  <= exit_d;
  end

  // narrowing is max over entries and low, min over exits and high, done as a small tree
  assign lo_a = (entry_q[0] > low_q)      ? entry_q[0] : low_q;
  assign lo_b = (entry_q[1] > entry_q[2]) ? entry_q[1] : entry_q[2];
  assign lo_d = (lo_a > lo_b)             ? lo_a       : lo_b;
  assign hi_a = (exit_q[0] < high_q)      ? exit_q[0]  : high_q;
  assign hi_b = (exit_q[1] < exit_q[2])   ? exit_q[1]  : exit_q[2];
  assign hi_d = (hi_a < hi_b)             ? hi_a       : hi_b;

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign done_o = vld_q[Depth-1];

  always_comb begin
    res_o.is_hit    = hi_q > lo_q;
    res_o.near_dist = lo_q;
    res_o.far_dist  = hi_q;
    res_o.tag_out   = tag_q[Depth-1];
  end

endmodule

`default_nettype wire

[design/rbs_checker.sv]
`default_nettype none

module rbs_checker
  import rbs_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    start_i,
  input wire logic    busy_o,
  input wire box_t    box_i,
  input wire logic    done_o,
  input wire result_t res_o
);

  // every taken box comes out on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("result missing five cycles after a transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without a matching transaction");

  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 (res_o.tag_out == $past(box_i.box_tag, 5)))
    else $error("tag not carried through");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.is_hit) |-> (res_o.far_dist > res_o.near_dist))
    else $error("hit with empty interval");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .box_i  (box_i),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

[tb/tb_ray_box_slab_test.sv]
`default_nettype none

module tb_ray_box_slab_test;
  import rbs_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int          ONE          = 1 << FRAC_BITS;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  coord_t             cfg_data_i;
  logic               start_i;
  logic               busy_o;
  box_t               box_i;
  logic               done_o;
  result_t            res_o;

  ray_box_slab_test #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .box_i     (box_i),
    .done_o    (done_o),
    .res_o     (res_o)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the ray registers
  coord_t ray_org[Axes];
  coord_t ray_rcp[Axes];
  coord_t ray_low;
  coord_t ray_high;

  result_t     pending_results[$];
  int unsigned boxes_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned rays_loaded;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          burst_mode;

  // (bound - origin) * recip, floored, saturated to 32 bits
  function automatic longint slab_distance(coord_t bound, coord_t org, coord_t rcp);
    longint span;
    longint prod;
    longint q;
    span = longint'(bound) - longint'(org);
    prod = span * longint'(rcp);
    q = prod >>> FRAC_BITS;
    if (q > longint'(CoordMax)) q = longint'(CoordMax);
    if (q < longint'(CoordMin)) q = longint'(CoordMin);
    return q;
  endfunction

  function automatic result_t slab_test_predict(box_t bx);
    result_t res;
    coord_t  mins[Axes];
    coord_t  maxs[Axes];
    longint  lo;
    longint  hi;
    longint  a;
    longint  b;
    mins = '{bx.box_min_x, bx.box_min_y, bx.box_min_z};
    maxs = '{bx.box_max_x, bx.box_max_y, bx.box_max_z};
    lo = longint'(ray_low);
    hi = longint'(ray_high);
    for (int ax = 0; ax < Axes; ax++) begin
      a = slab_distance(mins[ax], ray_org[ax], ray_rcp[ax]);
      b = slab_distance(maxs[ax], ray_org[ax], ray_rcp[ax]);
      if (a > b) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      if (a > lo) lo = a;
      if (b < hi) hi = b;
    end
    res.is_hit    = hi > lo;
    res.near_dist = coord_t'(lo);
    res.far_dist  = coord_t'(hi);
    res.tag_out   = bx.box_tag;
    return res;
  endfunction

  function automatic box_t mk_box(coord_t x0, coord_t y0, coord_t z0,
                                  coord_t x1, coord_t y1, coord_t z1, tag_t tag);
    box_t bx;
    bx.box_min_x = x0;
    bx.box_min_y = y0;
    bx.box_min_z = z0;
    bx.box_max_x = x1;
    bx.box_max_y = y1;
    bx.box_max_z = z1;
    bx.box_tag   = tag;
    return bx;
  endfunction

  function automatic coord_t rand_near(int unsigned r);
    return coord_t'(int'($urandom_range(0, 2 * r)) - int'(r));
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return CoordMin;
      1: return CoordMax;
      2: return '0;
      3: return coord_t'(ONE);
      default: return '1;
    endcase
  endfunction

  function automatic box_t random_box();
    box_t   bx;
    coord_t mins[Axes];
    coord_t maxs[Axes];
    coord_t ctr;
    coord_t half;
    int     kind;
    kind = $urandom_range(0, 19);
    for (int ax = 0; ax < Axes; ax++) begin
      if (kind < 3) begin
        mins[ax] = $urandom;
        maxs[ax] = $urandom;
      end else if (kind == 3) begin
        mins[ax] = pick_extreme();
        maxs[ax] = pick_extreme();
      end else begin
        // box placed near the ray origin so that hits are common
        ctr  = ray_org[ax] + rand_near(8 * ONE);
        half = coord_t'($urandom_range(0, 4 * ONE));
        mins[ax] = ctr - half;
        maxs[ax] = ctr + half;
        if ($urandom_range(0, 7) == 0) begin
          mins[ax] = ctr + half;
          maxs[ax] = ctr - half;
        end
      end
    end
    bx = mk_box(mins[0], mins[1], mins[2], maxs[0], maxs[1], maxs[2], tag_t'($urandom));
    return bx;
  endfunction

  task automatic send_box(input box_t bx);
    int gap;
    start_i <= 1'b1;
    box_i   <= bx;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(slab_test_predict(bx));
    boxes_sent++;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input coord_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_X:      ray_org[0] = val;
      CFG_ORIGIN_Y:      ray_org[1] = val;
      CFG_ORIGIN_Z:      ray_org[2] = val;
      CFG_RECIP_DIR_X:   ray_rcp[0] = val;
      CFG_RECIP_DIR_Y:   ray_rcp[1] = val;
      CFG_RECIP_DIR_Z:   ray_rcp[2] = val;
      CFG_INTERVAL_LOW:  ray_low    = val;
      CFG_INTERVAL_HIGH: ray_high   = val;
      default: ;
    endcase
  endtask

  task automatic load_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                          input coord_t rx, input coord_t ry, input coord_t rz,
                          input coord_t lo, input coord_t hi);
    wait_idle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_RECIP_DIR_X, rx);
    write_reg(CFG_RECIP_DIR_Y, ry);
    write_reg(CFG_RECIP_DIR_Z, rz);
    write_reg(CFG_INTERVAL_LOW, lo);
    write_reg(CFG_INTERVAL_HIGH, hi);
    cfg_we_i <= 1'b0;
    rays_loaded++;
  endtask

  task automatic random_ray();
    coord_t regs[8];
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      for (int ax = 0; ax < Axes; ax++) begin
        regs[ax] = rand_near(8 * ONE);
        regs[ax + 3] = coord_t'($urandom_range(ONE / 4, ONE * 4));
        if ($urandom_range(0, 1)) regs[ax + 3] = -regs[ax + 3];
        // axis-parallel ray: software loads a saturated reciprocal
        if ($urandom_range(0, 7) == 0) regs[ax + 3] = $urandom_range(0, 1) ? CoordMax : CoordMin;
      end
      regs[6] = ($urandom_range(0, 3) == 0) ? rand_near(2 * ONE) : coord_t'(0);
      regs[7] = $urandom_range(0, 1) ? CoordMax : coord_t'($urandom_range(ONE, 32 * ONE));
    end else begin
      for (int i = 0; i < 8; i++) regs[i] = (kind == 9) ? pick_extreme() : coord_t'($urandom);
    end
    load_ray(regs[0], regs[1], regs[2], regs[3], regs[4], regs[5], regs[6], regs[7]);
  endtask

  task automatic test_reset_ray();
    // reset ray: origin 0, unit reciprocal, interval [0, max]
    send_box(mk_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 16'h0000));
    send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 16'hffff));
    send_box(mk_box(-3 * ONE, ONE, ONE, -2 * ONE, 2 * ONE, 2 * ONE, 16'h1234));
    send_box(mk_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, 16'h5a5a));
    send_box(mk_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin, 16'ha5a5));
    // slabs only touch: far equals near, a miss
    send_box(mk_box(ONE, 2 * ONE, 0, 2 * ONE, 3 * ONE, 4 * ONE, 16'h00ff));
  endtask

  task automatic test_edge_rays();
    // saturated reciprocals and extreme origins
    load_ray(CoordMin, CoordMax, 0, CoordMax, CoordMin, 0, CoordMin, CoordMax);
    send_box(mk_box(CoordMin, CoordMax, 0, CoordMin, CoordMax, 0, 16'h0001));
    send_box(mk_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, 16'h0002));
    send_box(mk_box(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, 16'h0003));
    send_box(mk_box(CoordMin, CoordMin, ONE, CoordMax, CoordMax, -ONE, 16'h0004));
    // inverted accepted interval
    load_ray(0, 0, 0, ONE, ONE, ONE, CoordMax, CoordMin);
    send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 16'h8000));
    send_box(mk_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, 16'h7fff));
    // empty interval, low equal to high
    load_ray(0, 0, 0, ONE, ONE, ONE, ONE, ONE);
    send_box(mk_box(-ONE, -ONE, -ONE, 4 * ONE, 4 * ONE, 4 * ONE, 16'h0f0f));
    // negative direction
    load_ray(4 * ONE, 4 * ONE, 4 * ONE, -ONE, -ONE, -ONE, 0, CoordMax);
    send_box(mk_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 16'hf0f0));
    // smallest reciprocal: negative products floor toward minus infinity
    load_ray(0, 0, 0, 1, 1, 1, CoordMin, CoordMax);
    send_box(mk_box(-1, -1, -1, 1, 1, 1, 16'h3c3c));
    send_box(mk_box(-ONE - 1, -3, -2, ONE + 1, 3, 2, 16'hc3c3));
  endtask

  task automatic test_back_to_back();
    random_ray();
    burst_mode = 1'b1;
    repeat (40) send_box(random_box());
    burst_mode = 1'b0;
    // hold off new boxes until the pipeline has drained
    wait_idle();
  endtask

  task automatic test_random_rays();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_ray();
      n = $urandom_range(10, 80);
      burst_mode = ($urandom_range(0, 4) == 0);
      repeat (n) send_box(random_box());
      burst_mode = 1'b0;
      sent += n;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      results_seen++;
      if (res_o.is_hit === 1'b1) hits_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no box outstanding, tag_out %h", res_o.tag_out);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.is_hit !== want.is_hit) begin
          $error("is_hit: expected %0d, got %0d", want.is_hit, res_o.is_hit);
          fail_cnt++;
        end
        if (res_o.near_dist !== want.near_dist) begin
          $error("near_dist: expected %0d, got %0d", want.near_dist, res_o.near_dist);
          fail_cnt++;
        end
        if (res_o.far_dist !== want.far_dist) begin
          $error("far_dist: expected %0d, got %0d", want.far_dist, res_o.far_dist);
          fail_cnt++;
        end
        if (res_o.tag_out !== want.tag_out) begin
          $error("tag_out: expected %h, got %h", want.tag_out, res_o.tag_out);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("tb_ray_box_slab_test NOT OK");
      $finish;
    end
  end

  initial begin
    boxes_sent   = 0;
    results_seen = 0;
    hits_seen    = 0;
    rays_loaded  = 0;
    fail_cnt     = 0;
    cycle_cnt    = 0;
    burst_mode   = 1'b0;
    ray_org  = '{default: '0};
    ray_rcp  = '{default: coord_t'(ONE)};
    ray_low  = '0;
    ray_high = CoordMax;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_ORIGIN_X;
    cfg_data_i <= '0;
    start_i    <= 1'b0;
    box_i      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_ray();
    test_edge_rays();
    test_back_to_back();
    test_random_rays();
    wait_idle();

    $display("%0d boxes under %0d ray settings (extremes, inverted interval, parallel axes)",
             boxes_sent, rays_loaded);
    $display("%0d results checked: %0d hits, %0d misses",
             results_seen, hits_seen, results_seen - hits_seen);
    if (fail_cnt == 0) begin
      $display("tb_ray_box_slab_test OK");
    end else begin
      $display("tb_ray_box_slab_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/rbs_pkg.sv
design/rbs_slab_lane.sv
design/ray_box_slab_test.sv
design/rbs_checker.sv
tb/tb_ray_box_slab_test.sv
